// ----- rtl/adpcm_pkg.sv -----
`default_nettype none
package adpcm_pkg;

  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam int FRAC_BITS = 11;
  localparam int ACC_W     = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic signed [15:0] SAT_HIGH = 16'sh7fff;
  localparam logic signed [15:0] SAT_LOW  = -16'sh8000;

  typedef struct packed {
    logic [1:0] func;
    logic       channel;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               out_channel;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic header;
    logic clear;
    logic mul;
    logic commit;
    logic second;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/adpcm_ctrl.sv -----
`default_nettype none
module adpcm_ctrl
  import adpcm_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire in_item_t   in_data,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       second;
  logic       second_next;
  logic       ch_ok;

  assign in_stall = (state != ST_IDLE);
  assign ch_ok    = (int'(in_data.channel) < CHANNELS);

  always_comb begin
    state_next  = state;
    second_next = second;
    cmd         = '0;
    cmd.second  = second;
    case (state)
      ST_IDLE: begin
        if (in_valid && ch_ok) begin
          case (in_data.func)
            FUNC_HEADER: cmd.header = 1'b1;
            FUNC_CLEAR:  cmd.clear = 1'b1;
            FUNC_DATA: begin
              cmd.start   = 1'b1;
              second_next = 1'b0;
              state_next  = ST_MUL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          if (second) begin
            state_next = ST_IDLE;
          end else begin
            second_next = 1'b1;
            state_next  = ST_MUL;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/adpcm_dp.sv -----
`default_nettype none
module adpcm_dp
  import adpcm_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire in_item_t             in_data,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data
);

  logic [CFG_W-1:0]   coef [CHANNELS][4];
  logic signed [15:0] hist_one [CHANNELS];
  logic signed [15:0] hist_two [CHANNELS];
  logic [3:0]         shift_amt [CHANNELS];
  logic [2:0]         pair_sel [CHANNELS];

  logic               ch;
  logic [7:0]         byte_r;
  logic signed [31:0] prod_one;
  logic signed [31:0] prod_two;

  logic [3:0]               nib;
  logic [2:0]               pair;
  logic [CFG_W-1:0]         coef_word;
  logic signed [15:0]       c_one;
  logic signed [15:0]       c_two;
  logic signed [ACC_W-1:0]  nib_ext;
  logic signed [ACC_W-1:0]  nib_scaled;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-FRAC_BITS-1:0] q;
  logic signed [15:0]       sat;
  logic                     cfg_ok;

  assign status.out_busy = out_valid && out_stall;

  assign nib        = cmd.second ? byte_r[3:0] : byte_r[7:4];
  assign pair       = pair_sel[ch];
  assign coef_word  = coef[ch][pair[2:1]];
  assign c_one      = coef_word[{pair[0], 5'd0} +: 16];
  assign c_two      = coef_word[{pair[0], 5'd16} +: 16];
  assign nib_ext    = {{(ACC_W-4){nib[3]}}, nib};
  assign nib_scaled = nib_ext <<< ({1'b0, shift_amt[ch]} + 5'd11);
  assign acc        = nib_scaled + ACC_W'(prod_one) + ACC_W'(prod_two) + 34'sd1024;
  assign q          = acc[ACC_W-1:FRAC_BITS];

  always_comb begin
    if (q > (ACC_W-FRAC_BITS)'(SAT_HIGH)) begin
      sat = SAT_HIGH;
    end else if (q < (ACC_W-FRAC_BITS)'(SAT_LOW)) begin
      sat = SAT_LOW;
    end else begin
      sat = q[15:0];
    end
  end

  assign cfg_ok = (int'(cfg_index[2]) < CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int w = 0; w < 4; w++) begin
          coef[c][w] <= '0;
        end
      end
    end else if (cfg_we && cfg_ok) begin
      coef[cfg_index[2]][cfg_index[1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        hist_one[c]  <= '0;
        hist_two[c]  <= '0;
        shift_amt[c] <= '0;
        pair_sel[c]  <= '0;
      end
    end else begin
      if (cmd.header) begin
        shift_amt[in_data.channel] <= in_data.data_byte[3:0];
        pair_sel[in_data.channel]  <= in_data.data_byte[6:4];
      end
      if (cmd.clear) begin
        hist_one[in_data.channel] <= '0;
        hist_two[in_data.channel] <= '0;
      end
      if (cmd.commit) begin
        hist_two[ch] <= hist_one[ch];
        hist_one[ch] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ch     <= in_data.channel;
      byte_r <= in_data.data_byte;
    end
    if (cmd.mul) begin
      prod_one <= c_one * hist_one[ch];
      prod_two <= c_two * hist_two[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.sample      <= sat;
      out_data.out_channel <= ch;
      out_data.last        <= cmd.second;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dsp_adpcm_decoder_unit.sv -----
// data byte: the byte is registered on accept, then the products, then the first sample in the output register
// a data byte holds the input until its second sample is committed (longer while the output register is stalled)
// header and clear requests do not stall the input; throughput is set by the shared multiply/accumulate
// rst is synchronous: clears history, scale, pair select, coefficients and the output valid
`default_nettype none
module dsp_adpcm_decoder_unit
  import adpcm_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  adpcm_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  adpcm_dp #(
    .CHANNELS(CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
